// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons in the next cycle");

`endif

// ----- rtl/dfem_pkg.sv -----
// ----------------------------------------------------------------------------
// dfem_pkg
// Types and constants of the dual FAT entry merge block.
// ----------------------------------------------------------------------------
package dfem_pkg;

  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned TC_W    = 28;

  // Entries at or above this value are end-of-chain markers.
  localparam logic [ENTRY_W-1:0] EOC_MIN  = 32'h0FFF_FFF8;
  // The bad-cluster marker.
  localparam logic [ENTRY_W-1:0] BAD_MARK = 32'h0FFF_FFF7;

  typedef enum logic [2:0] {
    ST_FREE    = 3'd0,
    ST_VALID   = 3'd1,
    ST_EOC     = 3'd2,
    ST_BAD     = 3'd3,
    ST_CORRUPT = 3'd4
  } status_t;

  // Classification of one entry as handed to the selection logic.
  typedef struct packed {
    status_t kind;
    logic    is_zero;
  } entry_class_t;

endpackage

// ----- rtl/dfem_ifs.sv -----
// ----------------------------------------------------------------------------
// dfem_ifs
// Valid/ready channel interfaces of the dual FAT entry merge block.
// ----------------------------------------------------------------------------
interface dfem_in_if;
  logic                         valid;
  logic                         ready;
  logic [dfem_pkg::ENTRY_W-1:0] primary_entry;
  logic [dfem_pkg::ENTRY_W-1:0] backup_entry;

  modport source (output valid, output primary_entry, output backup_entry, input ready);
  modport sink   (input valid, input primary_entry, input backup_entry, output ready);
endinterface

interface dfem_out_if;
  logic                         valid;
  logic                         ready;
  logic [dfem_pkg::ENTRY_W-1:0] merged_entry;
  logic [2:0]                   entry_status;

  modport source (output valid, output merged_entry, output entry_status, input ready);
  modport sink   (input valid, input merged_entry, input entry_status, output ready);
endinterface

interface dfem_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [dfem_pkg::TC_W-1:0] cluster_count;

  modport source (output valid, output cluster_count, input ready);
  modport sink   (input valid, input cluster_count, output ready);
endinterface

// ----- rtl/dfem_classify.sv -----
// ----------------------------------------------------------------------------
// dfem_classify
// Classifies one FAT32 entry as free, valid link, end of chain, bad or corrupt.
// ----------------------------------------------------------------------------
module dfem_classify (
  input  logic [dfem_pkg::ENTRY_W-1:0] entry,
  input  logic [dfem_pkg::ENTRY_W-1:0] top_link,
  output dfem_pkg::entry_class_t       cls
);

  always_comb begin
    cls.is_zero = (entry == '0);
    if (cls.is_zero) begin
      cls.kind = dfem_pkg::ST_FREE;
    end else if (entry >= dfem_pkg::EOC_MIN) begin
      cls.kind = dfem_pkg::ST_EOC;
    end else if (entry == dfem_pkg::BAD_MARK) begin
      cls.kind = dfem_pkg::ST_BAD;
    end else if ((entry >= dfem_pkg::ENTRY_W'(2)) && (entry <= top_link)) begin
      cls.kind = dfem_pkg::ST_VALID;
    end else begin
      cls.kind = dfem_pkg::ST_CORRUPT;
    end
  end

endmodule

// ----- rtl/dfem_select.sv -----
// ----------------------------------------------------------------------------
// dfem_select
// Picks the merged entry and its status from a classified entry pair.
// ----------------------------------------------------------------------------
module dfem_select (
  input  logic [dfem_pkg::ENTRY_W-1:0] primary_entry,
  input  logic [dfem_pkg::ENTRY_W-1:0] backup_entry,
  input  logic [dfem_pkg::ENTRY_W-1:0] top_link,
  output logic [dfem_pkg::ENTRY_W-1:0] merged_entry,
  output dfem_pkg::status_t            entry_status
);

  dfem_pkg::entry_class_t cls_a;
  dfem_pkg::entry_class_t cls_b;
  logic                   sane_a;
  logic                   sane_b;

  dfem_classify u_cls_a (.entry(primary_entry), .top_link(top_link), .cls(cls_a));
  dfem_classify u_cls_b (.entry(backup_entry),  .top_link(top_link), .cls(cls_b));

  // Free, valid and end of chain count as sane.
  assign sane_a = (cls_a.kind == dfem_pkg::ST_FREE) || (cls_a.kind == dfem_pkg::ST_VALID) ||
                  (cls_a.kind == dfem_pkg::ST_EOC);
  assign sane_b = (cls_b.kind == dfem_pkg::ST_FREE) || (cls_b.kind == dfem_pkg::ST_VALID) ||
                  (cls_b.kind == dfem_pkg::ST_EOC);

  always_comb begin
    merged_entry = primary_entry;
    entry_status = dfem_pkg::ST_CORRUPT;
    if (primary_entry == backup_entry) begin
      entry_status = cls_a.kind;
    end else if (sane_a && (cls_b.kind == dfem_pkg::ST_CORRUPT)) begin
      entry_status = cls_a.kind;
    end else if (sane_b && (cls_a.kind == dfem_pkg::ST_CORRUPT)) begin
      merged_entry = backup_entry;
      entry_status = cls_b.kind;
    end else if (cls_a.is_zero && (cls_b.kind != dfem_pkg::ST_CORRUPT)) begin
      merged_entry = backup_entry;
      entry_status = cls_b.kind;
    end else if (cls_b.is_zero && (cls_a.kind != dfem_pkg::ST_CORRUPT)) begin
      entry_status = cls_a.kind;
    end else if ((cls_a.kind == dfem_pkg::ST_VALID) && (cls_b.kind == dfem_pkg::ST_VALID)) begin
      entry_status = dfem_pkg::ST_VALID;
    end
  end

endmodule

// ----- rtl/dual_fat_entry_merge_core.sv -----
// ----------------------------------------------------------------------------
// dual_fat_entry_merge_core
// Merges primary and backup FAT32 entries into one entry with a status.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel takes one transaction per entry pair, the primary and
// backup FAT entries at the same index. The out_ch channel returns one
// transaction per pair, in order: the merged entry and its status code
// (free, valid link, end of chain, bad or corrupt).
// The cfg_ch channel writes the cluster count; it is always ready and should
// be written only while no pair is in flight.
// A pair accepted on in_ch is held in the input register, is classified and
// selected in one pass of comparators, and is then offered from the output
// register; a stall on out_ch can hold it in either register.
// Throughput is one pair per cycle while out_ch does not stall; both registers
// advance together whenever the output register is empty or being taken.
// When the receiver stalls, the output register holds its result and the
// input register fills; in_ch.ready drops only once both are occupied.
// Reset clears both valid flags and sets the cluster count to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_fat_entry_merge_core (
  input  logic        clk,
  input  logic        rst_n,
  dfem_in_if.sink     in_ch,
  dfem_out_if.source  out_ch,
  dfem_cfg_if.sink    cfg_ch
);

  // Configuration register.
  logic [dfem_pkg::TC_W-1:0]    cluster_count_r;
  // Highest valid link, cluster count + 2 on the full entry width.
  logic [dfem_pkg::ENTRY_W-1:0] top_link;

  // Input register stage.
  logic                         s1_valid_r;
  logic [dfem_pkg::ENTRY_W-1:0] s1_primary_r;
  logic [dfem_pkg::ENTRY_W-1:0] s1_backup_r;

  // Output register stage.
  logic                         out_valid_r;
  logic [dfem_pkg::ENTRY_W-1:0] out_entry_r;
  dfem_pkg::status_t            out_status_r;

  logic [dfem_pkg::ENTRY_W-1:0] merged_nxt;
  dfem_pkg::status_t            status_nxt;
  logic                         advance;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= '0;
    end else if (cfg_ch.valid) begin
      cluster_count_r <= cfg_ch.cluster_count;
    end
  end

  assign top_link = {{(dfem_pkg::ENTRY_W-dfem_pkg::TC_W){1'b0}}, cluster_count_r} +
                    dfem_pkg::ENTRY_W'(2);

  // The pipeline moves whenever the output register is free or being drained.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_primary_r <= in_ch.primary_entry;
      s1_backup_r  <= in_ch.backup_entry;
    end
  end

  dfem_select u_select (
    .primary_entry (s1_primary_r),
    .backup_entry  (s1_backup_r),
    .top_link      (top_link),
    .merged_entry  (merged_nxt),
    .entry_status  (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_entry_r  <= merged_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.merged_entry = out_entry_r;
  assign out_ch.entry_status = out_status_r;

  // A free result always carries the zero entry, a bad result the bad marker.
  `ASSERT_IMPLIES(a_free_is_zero, clk, rst_n,
    out_valid_r && (out_status_r == dfem_pkg::ST_FREE), out_entry_r == '0)
  `ASSERT_IMPLIES(a_bad_is_marker, clk, rst_n,
    out_valid_r && (out_status_r == dfem_pkg::ST_BAD), out_entry_r == dfem_pkg::BAD_MARK)
  // An accepted pair always lands in the input register.
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_ch.valid && in_ch.ready, s1_valid_r)
  // A held pair in the input register is never dropped during a stall.
  `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !advance, s1_valid_r && out_valid_r)

endmodule
